FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shorthand for clocked assertions; expects i_clk and i_rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SFBC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SFBC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/sfbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfbc_pkg
// Types, codes and defaults shared by the free block cache modules.
// ----------------------------------------------------------------------------
package sfbc_pkg;

    localparam int SHARD_COUNT_DEF    = 16;
    localparam int SHARD_CAPACITY_DEF = 4;
    localparam int HEADER_BYTES_DEF   = 16;
    localparam int SIZE_GRANULE_DEF   = 1024;

    localparam int DIV_STEPS = 5;
    localparam int DIV_CW    = 3;

    localparam logic [1:0] FUNC_GET       = 2'd0;
    localparam logic [1:0] FUNC_RELEASE   = 2'd1;
    localparam logic [1:0] FUNC_FLUSH     = 2'd2;
    localparam logic [1:0] FUNC_FLUSH_OLD = 2'd3;

    localparam logic [1:0] LVL_NONE    = 2'd0;
    localparam logic [1:0] LVL_QUARTER = 2'd1;
    localparam logic [1:0] LVL_HALF    = 2'd2;
    localparam logic [1:0] LVL_ALL     = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] request_size;
        logic [31:0] block_addr;
        logic [1:0]  pressure;
    } t_item;

    typedef struct packed {
        logic        hit;
        logic [31:0] user_addr;
        logic        free_valid;
        logic [31:0] free_addr;
        logic [6:0]  cached_total;
        logic        last;
    } t_result;

    typedef struct packed {
        logic load;
        logic div_step;
        logic set_home;
        logic next_shard;
        logic rd_slot;
        logic rd_next;
        logic wr_shift;
        logic slot_inc;
        logic rm_done;
        logic cap_found;
        logic append;
        logic load_cut;
        logic cut_dec;
        logic emit_hit;
        logic emit_miss;
        logic emit_rel;
        logic pend_push;
        logic flush_end;
    } t_cmd;

    typedef struct packed {
        logic [1:0] func;
        logic       div_done;
        logic       slot_lt_fill;
        logic       next_lt_fill;
        logic       fits;
        logic       full;
        logic       adv_done;
        logic       cut_zero;
    } t_stat;

endpackage

FILE: hw/rtl/sfbc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfbc_dp
// Datapath: entry memory, shard fill counts, home shard calculation, cursors,
// result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sfbc_dp #(
    parameter int SHARD_COUNT    = sfbc_pkg::SHARD_COUNT_DEF,
    parameter int SHARD_CAPACITY = sfbc_pkg::SHARD_CAPACITY_DEF,
    parameter int HEADER_BYTES   = sfbc_pkg::HEADER_BYTES_DEF,
    parameter int SIZE_GRANULE   = sfbc_pkg::SIZE_GRANULE_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sfbc_pkg::t_item   i_item,
    input  sfbc_pkg::t_cmd    i_cmd,
    output sfbc_pkg::t_stat   o_stat,
    output sfbc_pkg::t_result o_result,
    output logic              o_result_stb
);
    import sfbc_pkg::*;

    localparam int SLOTS = SHARD_COUNT * SHARD_CAPACITY;
    localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SW    = (SHARD_COUNT > 1) ? $clog2(SHARD_COUNT) : 1;
    localparam int FW    = $clog2(SHARD_CAPACITY + 1);
    localparam int TW    = $clog2(SLOTS + 1);

    // reciprocal constants: floor(n / d) == (n * ceil(2^s / d)) >> s for 32-bit n
    localparam int G_SH = 32 + $clog2(SIZE_GRANULE);
    localparam int N_SH = 32 + $clog2(SHARD_COUNT);
    localparam logic [63:0] G_MAG =
        ((64'd1 << G_SH) + 64'(SIZE_GRANULE) - 64'd1) / 64'(SIZE_GRANULE);
    localparam logic [63:0] N_MAG =
        ((64'd1 << N_SH) + 64'(SHARD_COUNT) - 64'd1) / 64'(SHARD_COUNT);

    function automatic logic [IW-1:0] f_idx(input logic [SW-1:0] s,
                                            input logic [FW:0] k);
        return IW'(int'(s) * SHARD_CAPACITY + int'(k));
    endfunction

    t_item             r_req;
    logic [32:0]       r_need;
    logic [31:0]       r_dsr;
    logic [31:0]       r_qg;
    logic [64:0]       r_acc;
    logic [DIV_CW-1:0] r_dcnt;
    logic [SW-1:0]     r_mod;
    logic [SW-1:0]     r_shard;
    logic [FW-1:0]     r_slot;
    logic              r_home_phase;
    logic [FW-1:0]     r_cut;
    logic [31:0]       r_found;
    logic              r_evict;
    logic              r_pend_vld;
    logic [31:0]       r_pend_addr;
    logic [TW-1:0]     r_pend_total;
    logic [FW-1:0]     r_fill [SHARD_COUNT];
    logic [TW-1:0]     r_total;
    logic [63:0]       r_mem [SLOTS];
    logic [63:0]       r_rd;
    t_result           r_out;
    logic              r_out_stb;

    logic [32:0]   w_mag;
    logic [16:0]   w_half;
    logic [48:0]   w_pp;
    logic [64:0]   w_sum;
    logic [31:0]   w_quo;
    logic [31:0]   w_rem;
    logic [SW-1:0] w_home;
    logic [FW-1:0] w_fill;
    logic [SW:0]   w_cand0;
    logic [SW:0]   w_cand;
    logic [FW-1:0] w_cut;
    logic [FW:0]   w_rd_k;
    logic [IW-1:0] w_wr_idx;
    logic [63:0]   w_wr_data;
    t_result       n_out;
    logic          n_out_stb;

    // home shard: steps 0-1 size / granule, 2-3 that / shards, 4 remainder
    assign w_mag  = (r_dcnt < DIV_CW'(2)) ? G_MAG[32:0] : N_MAG[32:0];
    assign w_half = r_dcnt[0] ? w_mag[32:16] : {1'b0, w_mag[15:0]};
    assign w_pp   = 49'(r_dsr) * 49'(w_half);
    assign w_sum  = r_acc + {w_pp, 16'b0};
    assign w_quo  = r_dcnt[1] ? 32'(w_sum >> N_SH) : 32'(w_sum >> G_SH);
    assign w_rem  = r_qg - 32'(r_dsr * 32'(SHARD_COUNT));
    assign w_home = r_mod;

    assign w_fill = r_fill[r_shard];

    // next shard in scan order; a get skips its home shard
    always_comb begin
        w_cand0 = r_home_phase ? '0 : {1'b0, r_shard} + 1'b1;
        w_cand  = w_cand0;
        if (r_req.func == FUNC_GET && w_cand0 == {1'b0, w_home}) begin
            w_cand = w_cand0 + 1'b1;
        end
    end

    always_comb begin
        w_cut = '0;
        if (r_req.func == FUNC_FLUSH_OLD) begin
            w_cut = w_fill >> 1;
        end else begin
            unique case (r_req.pressure)
                LVL_NONE:    w_cut = '0;
                LVL_QUARTER: w_cut = w_fill >> 2;
                LVL_HALF:    w_cut = w_fill >> 1;
                LVL_ALL:     w_cut = w_fill;
                default:     w_cut = '0;
            endcase
        end
    end

    assign w_rd_k    = i_cmd.rd_next ? {1'b0, r_slot} + 1'b1 : {1'b0, r_slot};
    assign w_wr_idx  = i_cmd.append ? f_idx(r_shard, {1'b0, w_fill})
                                    : f_idx(r_shard, {1'b0, r_slot});
    assign w_wr_data = i_cmd.append ? {r_req.block_addr, r_req.request_size} : r_rd;

    always_comb begin
        o_stat.func         = r_req.func;
        o_stat.div_done     = r_dcnt == DIV_CW'(DIV_STEPS);
        o_stat.slot_lt_fill = r_slot < w_fill;
        o_stat.next_lt_fill = ({1'b0, r_slot} + 1'b1) < {1'b0, w_fill};
        o_stat.fits         = {1'b0, r_rd[31:0]} >= r_need;
        o_stat.full         = w_fill >= FW'(SHARD_CAPACITY);
        o_stat.adv_done     = w_cand >= (SW+1)'(SHARD_COUNT);
        o_stat.cut_zero     = r_cut == '0;
    end

    // result builder
    always_comb begin
        n_out     = '0;
        n_out_stb = 1'b0;
        if (i_cmd.emit_hit) begin
            n_out.hit          = 1'b1;
            n_out.user_addr    = r_found + 32'(HEADER_BYTES);
            n_out.cached_total = 7'(r_total);
            n_out.last         = 1'b1;
            n_out_stb          = 1'b1;
        end else if (i_cmd.emit_miss) begin
            n_out.cached_total = 7'(r_total);
            n_out.last         = 1'b1;
            n_out_stb          = 1'b1;
        end else if (i_cmd.emit_rel) begin
            n_out.free_valid   = r_evict;
            n_out.free_addr    = r_evict ? r_found : '0;
            n_out.cached_total = 7'(r_total + 1'b1);
            n_out.last         = 1'b1;
            n_out_stb          = 1'b1;
        end else if (i_cmd.pend_push || i_cmd.flush_end) begin
            n_out.last = i_cmd.flush_end;
            n_out_stb  = r_pend_vld || i_cmd.flush_end;
            if (r_pend_vld) begin
                n_out.free_valid   = 1'b1;
                n_out.free_addr    = r_pend_addr;
                n_out.cached_total = 7'(r_pend_total);
            end else begin
                n_out.cached_total = 7'(r_total);
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SHARD_COUNT; i++) begin
                r_fill[i] <= '0;
            end
            r_total    <= '0;
            r_out_stb  <= 1'b0;
            r_pend_vld <= 1'b0;
        end else begin
            r_out_stb <= n_out_stb;
            if (i_cmd.rm_done) begin
                r_fill[r_shard] <= w_fill - 1'b1;
                r_total         <= r_total - 1'b1;
            end else if (i_cmd.append) begin
                r_fill[r_shard] <= w_fill + 1'b1;
                r_total         <= r_total + 1'b1;
            end
            if (i_cmd.load || i_cmd.flush_end) begin
                r_pend_vld <= 1'b0;
            end else if (i_cmd.pend_push) begin
                r_pend_vld <= 1'b1;
            end
        end
    end

    // payload and cursors
    always_ff @(posedge i_clk) begin
        if (n_out_stb) begin
            r_out <= n_out;
        end
        if (i_cmd.load) begin
            r_req        <= i_item;
            r_need       <= {1'b0, i_item.request_size} + 33'(HEADER_BYTES);
            r_dsr        <= i_item.request_size;
            r_dcnt       <= '0;
            r_mod        <= '0;
            r_shard      <= '0;
            r_slot       <= '0;
            r_home_phase <= 1'b0;
            r_evict      <= 1'b0;
        end
        if (i_cmd.div_step) begin
            r_dcnt <= r_dcnt + 1'b1;
            if (r_dcnt == DIV_CW'(DIV_STEPS - 1)) begin
                r_mod <= SW'(w_rem);
            end else if (!r_dcnt[0]) begin
                r_acc <= 65'(w_pp);
            end else begin
                r_dsr <= w_quo;
                if (!r_dcnt[1]) begin
                    r_qg <= w_quo;
                end
            end
        end
        if (i_cmd.set_home) begin
            r_shard      <= w_home;
            r_slot       <= '0;
            r_home_phase <= r_req.func == FUNC_GET;
        end
        if (i_cmd.next_shard) begin
            r_shard      <= SW'(w_cand);
            r_slot       <= '0;
            r_home_phase <= 1'b0;
        end
        if (i_cmd.slot_inc) begin
            r_slot <= r_slot + 1'b1;
        end
        if (i_cmd.rm_done) begin
            r_slot <= '0;
        end
        if (i_cmd.cap_found) begin
            r_found <= r_rd[63:32];
            r_evict <= 1'b1;
        end
        if (i_cmd.load_cut) begin
            r_cut <= w_cut;
        end
        if (i_cmd.cut_dec) begin
            r_cut <= r_cut - 1'b1;
        end
        if (i_cmd.pend_push) begin
            r_pend_addr  <= r_rd[63:32];
            r_pend_total <= r_total - 1'b1;
        end
        if (i_cmd.rd_slot || i_cmd.rd_next) begin
            r_rd <= r_mem[f_idx(r_shard, w_rd_k)];
        end
        if (i_cmd.wr_shift || i_cmd.append) begin
            r_mem[w_wr_idx] <= w_wr_data;
        end
    end

    assign o_result     = r_out;
    assign o_result_stb = r_out_stb;

    `SFBC_ASSERT_IMP(a_append_room, i_cmd.append, w_fill < FW'(SHARD_CAPACITY), "append to full shard")
    `SFBC_ASSERT_IMP(a_rm_nonempty, i_cmd.rm_done, w_fill != '0 && r_total != '0, "remove from empty shard")

endmodule

FILE: hw/rtl/sfbc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfbc_ctrl
// Sequencer for get, release and flush operations.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sfbc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  logic [1:0]      i_func,
    input  sfbc_pkg::t_stat i_stat,
    output sfbc_pkg::t_cmd  o_cmd,
    output logic            busy
);
    import sfbc_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE    = 14'b00000000000001,
        S_DIV     = 14'b00000000000010,
        S_G_SCAN  = 14'b00000000000100,
        S_G_CMP   = 14'b00000000001000,
        S_G_HIT   = 14'b00000000010000,
        S_REL_CHK = 14'b00000000100000,
        S_REL_EV  = 14'b00000001000000,
        S_REL_APP = 14'b00000010000000,
        S_F_CUT   = 14'b00000100000000,
        S_F_CHK   = 14'b00001000000000,
        S_F_GOT   = 14'b00010000000000,
        S_F_END   = 14'b00100000000000,
        S_R_RD    = 14'b01000000000000,
        S_R_WR    = 14'b10000000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = (i_func == FUNC_GET || i_func == FUNC_RELEASE)
                                 ? S_DIV : S_F_CUT;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.set_home = 1'b1;
                    n_state = (i_stat.func == FUNC_GET) ? S_G_SCAN : S_REL_CHK;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_G_SCAN: begin
                if (i_stat.slot_lt_fill) begin
                    o_cmd.rd_slot = 1'b1;
                    n_state       = S_G_CMP;
                end else if (i_stat.adv_done) begin
                    o_cmd.emit_miss = 1'b1;
                    n_state         = S_IDLE;
                end else begin
                    o_cmd.next_shard = 1'b1;
                end
            end
            S_G_CMP: begin
                if (i_stat.fits) begin
                    o_cmd.cap_found = 1'b1;
                    n_state         = S_R_RD;
                end else begin
                    o_cmd.slot_inc = 1'b1;
                    n_state        = S_G_SCAN;
                end
            end
            S_G_HIT: begin
                o_cmd.emit_hit = 1'b1;
                n_state        = S_IDLE;
            end
            S_REL_CHK: begin
                if (i_stat.full) begin
                    o_cmd.rd_slot = 1'b1;
                    n_state       = S_REL_EV;
                end else begin
                    n_state = S_REL_APP;
                end
            end
            S_REL_EV: begin
                o_cmd.cap_found = 1'b1;
                n_state         = S_R_RD;
            end
            S_REL_APP: begin
                o_cmd.append   = 1'b1;
                o_cmd.emit_rel = 1'b1;
                n_state        = S_IDLE;
            end
            S_F_CUT: begin
                o_cmd.load_cut = 1'b1;
                n_state        = S_F_CHK;
            end
            S_F_CHK: begin
                if (!i_stat.cut_zero) begin
                    o_cmd.rd_slot = 1'b1;
                    n_state       = S_F_GOT;
                end else if (i_stat.adv_done) begin
                    n_state = S_F_END;
                end else begin
                    o_cmd.next_shard = 1'b1;
                    n_state          = S_F_CUT;
                end
            end
            S_F_GOT: begin
                o_cmd.pend_push = 1'b1;
                o_cmd.cut_dec   = 1'b1;
                n_state         = S_R_RD;
            end
            S_F_END: begin
                o_cmd.flush_end = 1'b1;
                n_state         = S_IDLE;
            end
            S_R_RD: begin
                if (i_stat.next_lt_fill) begin
                    o_cmd.rd_next = 1'b1;
                    n_state       = S_R_WR;
                end else begin
                    o_cmd.rm_done = 1'b1;
                    priority if (i_stat.func == FUNC_GET) begin
                        n_state = S_G_HIT;
                    end else if (i_stat.func == FUNC_RELEASE) begin
                        n_state = S_REL_APP;
                    end else begin
                        n_state = S_F_CHK;
                    end
                end
            end
            S_R_WR: begin
                o_cmd.wr_shift = 1'b1;
                o_cmd.slot_inc = 1'b1;
                n_state        = S_R_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = r_state != S_IDLE;

    `SFBC_ASSERT_NXT(a_start_leaves_idle, start && !busy, busy, "accepted word did not start work")

endmodule

FILE: hw/rtl/sharded_free_block_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sharded_free_block_cache
// Free block cache of (address, size) entries spread over size-class shards.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: a word on i_item is taken at a clock edge where start is
//   high and busy is low. func selects get, release, pressure flush or
//   flush-oldest-half. One word is in work at a time.
//   Output channel: each result word sits on o_result for one cycle with
//   o_result_stb high; the receiver cannot stall, so no backpressure exists.
//   A get or release gives one word; a flush gives one word per removed
//   block (shard 0 upward, oldest first), or one empty word; last marks the
//   final word of an operation.
//   Sequence: get/release first compute the home shard (reciprocal
//   multiplies for size / granule and mod shards, each split in halves).
//   A get then compares entries one by one, home shard first, then the
//   other shards in order; removing an entry reads and writes back each
//   younger entry in turn to move it up (single-port entry memory). A
//   flush removes each cut block and moves the younger entries up
//   likewise. A word appears the cycle after it is issued; the last one
//   shows in the first cycle busy is low.
//   Reset: synchronous, active low; empties all shards. Entry memory holds
//   garbage until written and needs no clearing pass.
// ----------------------------------------------------------------------------

module sharded_free_block_cache #(
    parameter int SHARD_COUNT    = sfbc_pkg::SHARD_COUNT_DEF,
    parameter int SHARD_CAPACITY = sfbc_pkg::SHARD_CAPACITY_DEF,
    parameter int HEADER_BYTES   = sfbc_pkg::HEADER_BYTES_DEF,
    parameter int SIZE_GRANULE   = sfbc_pkg::SIZE_GRANULE_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  sfbc_pkg::t_item   i_item,
    output logic              busy,
    output sfbc_pkg::t_result o_result,
    output logic              o_result_stb
);
    import sfbc_pkg::*;

    // command and status between sequencer and datapath
    t_cmd  w_cmd;
    t_stat w_stat;

    sfbc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_func  (i_item.func),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .busy    (busy)
    );

    sfbc_dp #(
        .SHARD_COUNT    (SHARD_COUNT),
        .SHARD_CAPACITY (SHARD_CAPACITY),
        .HEADER_BYTES   (HEADER_BYTES),
        .SIZE_GRANULE   (SIZE_GRANULE)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (i_item),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .o_result     (o_result),
        .o_result_stb (o_result_stb)
    );

endmodule

FILE: tb/sv/tb_sharded_free_block_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sharded_free_block_cache
// Self-checking bench for the sharded free block cache: a behavioral shard
// model predicts every result word of get, release and flush commands;
// words are compared in order against the block's strobed output.
// ----------------------------------------------------------------------------
module tb_sharded_free_block_cache;
    import sfbc_pkg::*;

    localparam int NSH   = SHARD_COUNT_DEF;
    localparam int CAP   = SHARD_CAPACITY_DEF;
    localparam int HDR   = HEADER_BYTES_DEF;
    localparam int GRAN  = SIZE_GRANULE_DEF;
    localparam int LIMIT = 2000000;

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start = 1'b0;
    t_item   i_item = '0;
    logic    busy;
    t_result o_result;
    logic    o_result_stb;

    sharded_free_block_cache u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .i_item(i_item),
        .busy(busy), .o_result(o_result), .o_result_stb(o_result_stb)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the shards, oldest entry at index 0.
    logic [31:0] sh_addr [NSH][CAP];
    logic [31:0] sh_len  [NSH][CAP];
    int          sh_fill [NSH];
    int          held;
    t_result     pending_words[$];
    int          fails = 0;
    int          cycles = 0;

    function automatic int home_of(logic [31:0] sz);
        return int'((sz / GRAN) % NSH);
    endfunction

    function automatic logic [31:0] drop_at(int s, int pos);
        logic [31:0] a;
        a = sh_addr[s][pos];
        for (int i = pos; i + 1 < sh_fill[s]; i++) begin
            sh_addr[s][i] = sh_addr[s][i+1];
            sh_len[s][i]  = sh_len[s][i+1];
        end
        sh_fill[s]--;
        held--;
        return a;
    endfunction

    function automatic void push_word(logic h, logic [31:0] ua, logic fv,
                                      logic [31:0] fa, logic lst);
        t_result r;
        r.hit = h; r.user_addr = ua; r.free_valid = fv; r.free_addr = fa;
        r.cached_total = held[6:0]; r.last = lst;
        pending_words = {pending_words, r};
    endfunction

    // Predict the words caused by one command.
    function automatic void predict_cache(t_item it);
        int          hm;
        int          n;
        int          cut;
        logic [32:0] need;
        logic [31:0] a;
        logic        found;
        hm = home_of(it.request_size);
        n = 0;
        found = 1'b0;
        if (it.func == FUNC_GET) begin
            need = {1'b0, it.request_size} + HDR;
            for (int k = -1; k < NSH && !found; k++) begin
                int s;
                s = (k < 0) ? hm : k;
                if (k >= 0 && s == hm) continue;
                for (int i = 0; i < sh_fill[s] && !found; i++)
                    if ({1'b0, sh_len[s][i]} >= need) begin
                        a = drop_at(s, i);
                        found = 1'b1;
                    end
            end
            if (found) push_word(1'b1, a + HDR, 1'b0, '0, 1'b1);
            else       push_word(1'b0, '0, 1'b0, '0, 1'b1);
        end else if (it.func == FUNC_RELEASE) begin
            logic ev;
            ev = 1'b0;
            a = '0;
            if (sh_fill[hm] >= CAP) begin
                a = drop_at(hm, 0);
                ev = 1'b1;
            end
            sh_addr[hm][sh_fill[hm]] = it.block_addr;
            sh_len[hm][sh_fill[hm]]  = it.request_size;
            sh_fill[hm]++;
            held++;
            push_word(1'b0, '0, ev, a, 1'b1);
        end else begin
            for (int s = 0; s < NSH; s++) begin
                if (it.func == FUNC_FLUSH_OLD)        cut = sh_fill[s] / 2;
                else if (it.pressure == LVL_QUARTER)  cut = sh_fill[s] / 4;
                else if (it.pressure == LVL_HALF)     cut = sh_fill[s] / 2;
                else if (it.pressure == LVL_ALL)      cut = sh_fill[s];
                else                                  cut = 0;
                for (int i = 0; i < cut; i++) begin
                    a = drop_at(s, 0);
                    push_word(1'b0, '0, 1'b1, a, 1'b0);
                    n++;
                end
            end
            if (n == 0) push_word(1'b0, '0, 1'b0, '0, 1'b1);
            else pending_words[$].last = 1'b1;
        end
    endfunction

    // Result checker: every strobed word against the oldest prediction.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_result_stb) begin
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected word %h", $time, o_result);
                fails++;
            end else begin
                t_result e;
                e = pending_words.pop_front();
                if (e.hit !== o_result.hit || e.user_addr !== o_result.user_addr ||
                    e.free_valid !== o_result.free_valid ||
                    e.free_addr !== o_result.free_addr ||
                    e.cached_total !== o_result.cached_total ||
                    e.last !== o_result.last) begin
                    $display("%0t: mismatch expected %h actual %h", $time, e, o_result);
                    fails++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    int burst_left = 0;

    // Send one command word, honoring burst/gap pacing.
    task automatic send_cmd(t_item it);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            if ($urandom_range(0, 2) != 0)
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
        end
        burst_left--;
        @(posedge i_clk);
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        predict_cache(it);
        start  <= 1'b0;
        i_item <= '0;
    endtask

    task automatic do_cmd(logic [1:0] f, logic [31:0] sz, logic [31:0] ad,
                          logic [1:0] lv);
        t_item it;
        it.func = f; it.request_size = sz; it.block_addr = ad; it.pressure = lv;
        send_cmd(it);
    endtask

    task automatic drain_words();
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic test_directed();
        do_cmd(FUNC_GET, 32'd0, 32'd0, LVL_NONE);              // empty miss
        do_cmd(FUNC_FLUSH, 32'd0, 32'd0, LVL_ALL);             // empty flush
        do_cmd(FUNC_RELEASE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, LVL_ALL);
        do_cmd(FUNC_RELEASE, 32'd0, 32'd0, LVL_NONE);
        for (int i = 0; i < 5; i++)                            // eviction
            do_cmd(FUNC_RELEASE, 32'd2048 + i, 32'h1000 * (i + 1), 2'($urandom));
        do_cmd(FUNC_GET, 32'hFFFF_FFF0, 32'd0, LVL_NONE);      // no-wrap miss
        do_cmd(FUNC_GET, 32'd2000, 32'hFFFF_FFFF, LVL_NONE);   // hit
        do_cmd(FUNC_GET, 32'hFFFF_FFEF, 32'd0, LVL_NONE);      // exact max hit
        do_cmd(FUNC_FLUSH, 32'd0, 32'd0, LVL_NONE);
        do_cmd(FUNC_FLUSH, 32'd0, 32'd0, LVL_QUARTER);
        do_cmd(FUNC_FLUSH_OLD, 32'd0, 32'd0, LVL_NONE);
        do_cmd(FUNC_FLUSH, 32'd0, 32'd0, LVL_HALF);
        do_cmd(FUNC_FLUSH, 32'd0, 32'd0, LVL_ALL);
        drain_words();
    endtask

    task automatic test_random();
        logic [31:0] sz;
        int          r;
        for (int n = 0; n < 133; n++) begin
            r = $urandom_range(0, 99);
            sz = ($urandom_range(0, 3) == 0) ? $urandom()
                 : $urandom_range(0, 20 * GRAN);
            if (r < 50) do_cmd(FUNC_RELEASE, sz, $urandom(), 2'($urandom()));
            else if (r < 85) do_cmd(FUNC_GET, sz, $urandom(), 2'($urandom()));
            else if (r < 95) do_cmd(FUNC_FLUSH, $urandom(), $urandom(), 2'($urandom()));
            else do_cmd(FUNC_FLUSH_OLD, $urandom(), $urandom(), 2'($urandom()));
            if (n == 66) drain_words();     // full pause mid-run
        end
        drain_words();
    endtask

    initial begin
        for (int s = 0; s < NSH; s++) sh_fill[s] = 0;
        held = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        if (fails == 0 && pending_words.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
